// ===== rtl/swaf_pkg.sv =====
// Shared constants for the sliding window anagram finder.
// Port widths, parameter defaults and operation codes; no dependencies.
package swaf_pkg;

   localparam int OPERATION_BITS   = 2;
   localparam int SYMBOL_PORT_BITS = 8;
   localparam int START_INDEX_BITS = 16;

   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int SYMBOL_BITS_DEFAULT = 8;
   localparam int INDEX_BITS_DEFAULT  = 16;

   localparam logic [OPERATION_BITS-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OPERATION_BITS-1:0] OP_PATTERN = 2'd1;
   localparam logic [OPERATION_BITS-1:0] OP_TEXT    = 2'd2;

endpackage

// ===== rtl/swaf_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read.
// Read returns the old contents when both ports hit the same address. No dependencies.
module swaf_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ===== rtl/sliding_window_anagram_finder.sv =====
// A matching window's start index passes through the count pipeline stage into the output register.
// A text symbol with a full window stalls the next item, since the count memory serves the
// incoming decrement and then the outgoing restore; other items do not stall on their own.
// A two-entry output stage stalls the input only while both entries hold results.
// Reset and clear items run a clearing pass over all 2**SYMBOL_BITS count memory entries,
// during which no item is taken. A clear waits until the count pipeline is empty.
module sliding_window_anagram_finder
   import swaf_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT,
   parameter int INDEX_BITS  = INDEX_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OPERATION_BITS-1:0]   req_operation,
   input  logic [SYMBOL_PORT_BITS-1:0] req_symbol,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [START_INDEX_BITS-1:0] rsp_start_index
);

   localparam int LEN_BITS  = $clog2(PATTERN_MAX + 1);
   localparam int PTR_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CNT_BITS  = LEN_BITS + 1;
   localparam int WORD_BITS = CNT_BITS + 1;
   localparam int SYM_COUNT = 1 << SYMBOL_BITS;
   localparam int SUB_BITS  = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;

   localparam logic [1:0] KIND_PAT = 2'd0;
   localparam logic [1:0] KIND_TXT = 2'd1;
   localparam logic [1:0] KIND_RST = 2'd2;

   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(PATTERN_MAX);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(PATTERN_MAX - 1);
   localparam logic [SYMBOL_BITS-1:0] SYM_LAST = SYMBOL_BITS'(SYM_COUNT - 1);

   // control state
   logic                   clearing_ff, clearing_in;
   logic [SYMBOL_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                   text_begun_ff, text_begun_in;
   logic [LEN_BITS-1:0]    pattern_length_ff, pattern_length_in;
   logic [LEN_BITS-1:0]    window_fill_ff, window_fill_in;
   logic [PTR_BITS-1:0]    ring_ptr_ff, ring_ptr_in;
   logic [PTR_BITS-1:0]    tail_ptr_ff, tail_ptr_in;
   logic [INDEX_BITS-1:0]  text_pos_ff, text_pos_in;
   logic [LEN_BITS-1:0]    unbal_ff, unbal_in;

   // count pipeline stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [1:0]             s1_kind_ff, s1_kind_in;
   logic [SYMBOL_BITS-1:0] s1_sym_ff, s1_sym_in;
   logic                   s1_full_ff, s1_full_in;
   logic                   s1_self_ff, s1_self_in;
   logic [INDEX_BITS-1:0]  s1_start_ff, s1_start_in;

   // write forwarding
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [SYMBOL_BITS-1:0] fwd_addr_ff, fwd_addr_in;
   logic [WORD_BITS-1:0]   fwd_data_ff, fwd_data_in;

   // output registers: head drives the port, spare takes a result while the head is held
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [START_INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic                        spare_valid_ff, spare_valid_in;
   logic [START_INDEX_BITS-1:0] spare_index_ff, spare_index_in;

   logic                   accept;
   logic [SYMBOL_BITS-1:0] sym;
   logic                   is_clear, is_pattern, is_text;
   logic                   take_pattern, take_text;
   logic                   restore_pending;
   logic [LEN_BITS:0]      fill_inc;
   logic                   full_now;
   logic [SUB_BITS-1:0]    start_wide;

   logic [SYMBOL_BITS-1:0] ring_rd_data;
   logic [SYMBOL_BITS-1:0] leave_sym;
   logic [SYMBOL_BITS-1:0] cnt_rd_addr;
   logic [WORD_BITS-1:0]   cnt_rd_data;
   logic                   cnt_wr_en;
   logic [SYMBOL_BITS-1:0] cnt_wr_addr;
   logic [WORD_BITS-1:0]   cnt_wr_data;

   logic [WORD_BITS-1:0]       cur_word;
   logic signed [CNT_BITS-1:0] cur_cnt;
   logic signed [CNT_BITS-1:0] new_cnt;
   logic                       cur_inp;
   logic                       new_inp;
   logic [LEN_BITS-1:0]        unbal_next;
   logic                       result_load;
   logic                       rsp_pop;
   logic [START_INDEX_BITS-1:0] new_index;

   assign sym        = SYMBOL_BITS'(req_symbol);
   assign is_clear   = (req_operation == OP_CLEAR);
   assign is_pattern = (req_operation == OP_PATTERN);
   assign is_text    = (req_operation == OP_TEXT);

   assign restore_pending = s1_valid_ff && (s1_kind_ff == KIND_TXT) && s1_full_ff;

   assign req_stall = clearing_ff || restore_pending || spare_valid_ff ||
                      (is_clear && s1_valid_ff);
   assign accept    = req_valid && !req_stall;

   assign take_pattern = accept && is_pattern && !text_begun_ff && (pattern_length_ff < LEN_MAX);
   assign take_text    = accept && is_text && (pattern_length_ff != '0);

   assign fill_inc   = {1'b0, window_fill_ff} + 1'b1;
   assign full_now   = (fill_inc >= {1'b0, pattern_length_ff});
   assign start_wide = SUB_BITS'(text_pos_ff) + 1'b1 - SUB_BITS'(pattern_length_ff);

   // window bookkeeping at transfer time
   always_comb begin
      clearing_in       = clearing_ff;
      clr_addr_in       = clr_addr_ff;
      text_begun_in     = text_begun_ff;
      pattern_length_in = pattern_length_ff;
      window_fill_in    = window_fill_ff;
      ring_ptr_in       = ring_ptr_ff;
      tail_ptr_in       = tail_ptr_ff;
      text_pos_in       = text_pos_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SYM_LAST) begin
            clearing_in = 1'b0;
         end
      end
      if (accept) begin
         unique case (req_operation)
            OP_CLEAR: begin
               clearing_in       = 1'b1;
               clr_addr_in       = '0;
               text_begun_in     = 1'b0;
               pattern_length_in = '0;
               window_fill_in    = '0;
               ring_ptr_in       = '0;
               tail_ptr_in       = '0;
               text_pos_in       = '0;
            end
            OP_PATTERN: begin
               if (take_pattern) begin
                  pattern_length_in = pattern_length_ff + 1'b1;
               end
            end
            OP_TEXT: begin
               text_begun_in = 1'b1;
               text_pos_in   = text_pos_ff + 1'b1;
               if (take_text) begin
                  window_fill_in = full_now ? pattern_length_ff : fill_inc[LEN_BITS-1:0];
                  ring_ptr_in    = (ring_ptr_ff == PTR_LAST) ? '0 : ring_ptr_ff + 1'b1;
                  if (full_now) begin
                     tail_ptr_in = (tail_ptr_ff == PTR_LAST) ? '0 : tail_ptr_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign leave_sym   = s1_self_ff ? s1_sym_ff : ring_rd_data;
   assign cnt_rd_addr = restore_pending ? leave_sym : sym;

   always_comb begin
      s1_valid_in = 1'b0;
      s1_kind_in  = KIND_PAT;
      s1_sym_in   = sym;
      s1_full_in  = 1'b0;
      s1_self_in  = 1'b0;
      s1_start_in = start_wide[INDEX_BITS-1:0];
      if (restore_pending) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = KIND_RST;
         s1_sym_in   = leave_sym;
      end else if (take_pattern) begin
         s1_valid_in = 1'b1;
      end else if (take_text) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = KIND_TXT;
         s1_full_in  = full_now;
         s1_self_in  = (pattern_length_ff == LEN_BITS'(1));
      end
   end

   // count read-modify-write
   assign cur_word = (fwd_valid_ff && (fwd_addr_ff == s1_sym_ff)) ? fwd_data_ff : cnt_rd_data;
   assign cur_cnt  = cur_word[CNT_BITS-1:0];
   assign cur_inp  = cur_word[CNT_BITS];

   always_comb begin
      new_cnt    = cur_cnt;
      new_inp    = cur_inp;
      unbal_next = unbal_ff;
      case (s1_kind_ff)
         KIND_PAT: begin
            new_cnt = cur_cnt + 2'sd1;
            new_inp = 1'b1;
            if (cur_cnt == '0) begin
               unbal_next = unbal_ff + 1'b1;
            end
         end
         KIND_TXT: begin
            if (cur_inp) begin
               new_cnt = cur_cnt - 2'sd1;
               if (cur_cnt == CNT_BITS'(1)) begin
                  unbal_next = unbal_ff - 1'b1;
               end
            end
         end
         default: begin
            if (cur_inp) begin
               new_cnt = cur_cnt + 2'sd1;
               if (cur_cnt == '0) begin
                  unbal_next = unbal_ff + 1'b1;
               end
            end
         end
      endcase
   end

   assign cnt_wr_en   = clearing_ff || s1_valid_ff;
   assign cnt_wr_addr = clearing_ff ? clr_addr_ff : s1_sym_ff;
   assign cnt_wr_data = clearing_ff ? '0 : {new_inp, new_cnt};

   assign fwd_valid_in = s1_valid_ff;
   assign fwd_addr_in  = s1_sym_ff;
   assign fwd_data_in  = {new_inp, new_cnt};

   always_comb begin
      unbal_in = unbal_ff;
      if (accept && is_clear) begin
         unbal_in = '0;
      end else if (s1_valid_ff) begin
         unbal_in = unbal_next;
      end
   end

   assign result_load = s1_valid_ff && (s1_kind_ff == KIND_TXT) && s1_full_ff &&
                        (unbal_next == '0);
   assign rsp_pop     = rsp_valid_ff && !rsp_stall;
   assign new_index   = START_INDEX_BITS'(s1_start_ff);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      spare_valid_in = spare_valid_ff;
      spare_index_in = spare_index_ff;
      if (rsp_pop) begin
         rsp_valid_in   = spare_valid_ff;
         rsp_index_in   = spare_index_ff;
         spare_valid_in = 1'b0;
      end
      if (result_load) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_index_in = new_index;
         end else begin
            spare_valid_in = 1'b1;
            spare_index_in = new_index;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff       <= 1'b1;
         clr_addr_ff       <= '0;
         text_begun_ff     <= 1'b0;
         pattern_length_ff <= '0;
         window_fill_ff    <= '0;
         ring_ptr_ff       <= '0;
         tail_ptr_ff       <= '0;
         text_pos_ff       <= '0;
         unbal_ff          <= '0;
         s1_valid_ff       <= 1'b0;
         fwd_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         spare_valid_ff    <= 1'b0;
      end else begin
         clearing_ff       <= clearing_in;
         clr_addr_ff       <= clr_addr_in;
         text_begun_ff     <= text_begun_in;
         pattern_length_ff <= pattern_length_in;
         window_fill_ff    <= window_fill_in;
         ring_ptr_ff       <= ring_ptr_in;
         tail_ptr_ff       <= tail_ptr_in;
         text_pos_ff       <= text_pos_in;
         unbal_ff          <= unbal_in;
         s1_valid_ff       <= s1_valid_in;
         fwd_valid_ff      <= fwd_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         spare_valid_ff    <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff     <= s1_kind_in;
      s1_sym_ff      <= s1_sym_in;
      s1_full_ff     <= s1_full_in;
      s1_self_ff     <= s1_self_in;
      s1_start_ff    <= s1_start_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_data_ff    <= fwd_data_in;
      rsp_index_ff   <= rsp_index_in;
      spare_index_ff <= spare_index_in;
   end

   swaf_ram #(
      .WIDTH     (SYMBOL_BITS),
      .DEPTH     (PATTERN_MAX),
      .ADDR_BITS (PTR_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (take_text),
      .wr_addr (ring_ptr_ff),
      .wr_data (sym),
      .rd_addr (tail_ptr_ff),
      .rd_data (ring_rd_data)
   );

   swaf_ram #(
      .WIDTH     (WORD_BITS),
      .DEPTH     (SYM_COUNT),
      .ADDR_BITS (SYMBOL_BITS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

`ifndef SYNTHESIS
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      !(result_load && spare_valid_ff))
      else $error("result loaded with both output entries taken");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      window_fill_ff <= pattern_length_ff)
      else $error("window fill exceeds pattern length");

   a_unbal_bounded: assert property (@(posedge clock) disable iff (reset)
      unbal_ff <= pattern_length_ff)
      else $error("unbalanced count exceeds pattern length");

   a_restore_follows_text: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_kind_ff == KIND_RST) |-> $past(restore_pending))
      else $error("restore without a full-window text symbol");

   a_clear_pass_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(clearing_ff && s1_valid_ff))
      else $error("count update during clearing pass");
`endif

endmodule

// ===== tb/sv/anagram_window_checker.sv =====
// Checker for the sliding window anagram finder: tracks pattern counts and the text window,
// predicts each matching start index and compares result transfers in order.
// Depends on swaf_pkg for port widths, parameter defaults and operation codes.
`timescale 1ns / 100ps

module anagram_window_checker
   import swaf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [OPERATION_BITS-1:0]   req_operation,
   input  logic [SYMBOL_PORT_BITS-1:0] req_symbol,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [START_INDEX_BITS-1:0] rsp_start_index,
   output int                          fail_count,
   output int                          pending
);

   localparam int WINDOW_MAX = PATTERN_MAX_DEFAULT;
   localparam int ALPHABET   = 1 << SYMBOL_BITS_DEFAULT;

   int                              shortfall [ALPHABET];
   bit                              wanted    [ALPHABET];
   int                              open_symbols;
   int                              word_len;
   logic [SYMBOL_BITS_DEFAULT-1:0]  recent [WINDOW_MAX];
   int                              held;
   int                              slot_next;
   logic [INDEX_BITS_DEFAULT-1:0]   text_pos;
   bit                              text_seen;
   logic [START_INDEX_BITS-1:0]     expected_starts [$];
   int                              errors = 0;

   task automatic clear_counts();
      for (int s = 0; s < ALPHABET; s++) begin
         shortfall[s] = 0;
         wanted[s]    = 1'b0;
      end
      open_symbols = 0;
      word_len     = 0;
      held         = 0;
      slot_next    = 0;
      text_pos     = '0;
      text_seen    = 1'b0;
   endtask

   task automatic track_window(input logic [OPERATION_BITS-1:0] op,
                               input logic [SYMBOL_BITS_DEFAULT-1:0] sym);
      logic [SYMBOL_BITS_DEFAULT-1:0] leaving;
      logic [INDEX_BITS_DEFAULT-1:0]  span;
      case (op)
         OP_CLEAR: begin
            clear_counts();
         end
         OP_PATTERN: begin
            if (!text_seen && word_len < WINDOW_MAX) begin
               if (shortfall[sym] == 0)
                  open_symbols++;
               shortfall[sym]++;
               wanted[sym] = 1'b1;
               word_len++;
            end
         end
         OP_TEXT: begin
            text_seen = 1'b1;
            if (word_len != 0) begin
               recent[slot_next] = sym;
               if (wanted[sym]) begin
                  shortfall[sym]--;
                  if (shortfall[sym] == 0)
                     open_symbols--;
               end
               if (held < word_len)
                  held++;
               if (held == word_len) begin
                  if (open_symbols == 0) begin
                     span = INDEX_BITS_DEFAULT'(word_len - 1);
                     expected_starts.insert(expected_starts.size(), text_pos - span);
                  end
                  // outgoing symbol gets its count back
                  leaving = recent[(slot_next + WINDOW_MAX + 1 - word_len) % WINDOW_MAX];
                  if (wanted[leaving]) begin
                     shortfall[leaving]++;
                     if (shortfall[leaving] == 1)
                        open_symbols++;
                  end
               end
               slot_next = (slot_next + 1) % WINDOW_MAX;
            end
            text_pos = text_pos + 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_counts();
         expected_starts.delete();
      end else begin
         if (req_valid && !req_stall)
            track_window(req_operation, req_symbol[SYMBOL_BITS_DEFAULT-1:0]);
         if (rsp_valid && !rsp_stall) begin
            if (expected_starts.size() == 0) begin
               $display("%0t: start_index expected none, actual %0d", $time, rsp_start_index);
               errors++;
            end else begin
               if (rsp_start_index !== expected_starts[0]) begin
                  $display("%0t: start_index expected %0d, actual %0d",
                           $time, expected_starts[0], rsp_start_index);
                  errors++;
               end
               void'(expected_starts.pop_front());
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_starts.size();
   end

endmodule

// ===== tb/sv/tb_sliding_window_anagram_finder.sv =====
// Top of the anagram finder testbench: clock, reset, request stimulus and result stalls.
// Instantiates sliding_window_anagram_finder and anagram_window_checker; uses swaf_pkg.
`timescale 1ns / 100ps

module tb_sliding_window_anagram_finder;
   import swaf_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1150;
   localparam int QUIET_TEXT   = 100;
   localparam int LONG_HOLD    = 800;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 300;
   localparam int RUN_LIMIT_NS = 10_000_000;
   localparam logic [OPERATION_BITS-1:0] OP_UNUSED = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [OPERATION_BITS-1:0]   req_operation;
   logic [SYMBOL_PORT_BITS-1:0] req_symbol;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [START_INDEX_BITS-1:0] rsp_start_index;
   int                          fail_count;
   int                          pending;

   bit quiet          = 1'b0;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;
   int sent_items     = 0;
   int sender_calm    = 0;

   always #HALF_PERIOD clock = ~clock;

   sliding_window_anagram_finder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_start_index (rsp_start_index)
   );

   anagram_window_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_start_index (rsp_start_index),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // one request transfer, with an occasional idle burst ahead of it
   task automatic send(input logic [OPERATION_BITS-1:0] op,
                       input logic [SYMBOL_PORT_BITS-1:0] sym);
      if (sender_calm > 0) begin
         sender_calm--;
      end else if (!quiet) begin
         if ($urandom_range(0, 39) == 0) begin
            sender_calm = $urandom_range(20, 120);
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_symbol    <= sym;
      do @(posedge clock); while (req_stall);
      if (op != OP_UNUSED)
         sent_items++;
   endtask

   // clear, a pattern over a small random alphabet, then text rich in anagrams with stray pattern and unknown items
   task automatic play_sequence(input int len, input int text_len);
      logic [SYMBOL_PORT_BITS-1:0] alphabet [4];
      logic [SYMBOL_PORT_BITS-1:0] word [72];
      logic [SYMBOL_PORT_BITS-1:0] swap;
      int kinds;
      int kept;
      int n;
      int i;
      int j;
      kinds = $urandom_range(1, 4);
      for (i = 0; i < 4; i++)
         alphabet[i] = SYMBOL_PORT_BITS'($urandom_range(0, 255));
      kept = (len < PATTERN_MAX_DEFAULT) ? len : PATTERN_MAX_DEFAULT;
      send(OP_CLEAR, SYMBOL_PORT_BITS'($urandom_range(0, 255)));
      for (i = 0; i < len; i++) begin
         word[i] = alphabet[$urandom_range(0, kinds - 1)];
         send(OP_PATTERN, word[i]);
      end
      n = 0;
      while (n < text_len) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               for (i = kept - 1; i > 0; i--) begin
                  j       = $urandom_range(0, i);
                  swap    = word[i];
                  word[i] = word[j];
                  word[j] = swap;
               end
               for (i = 0; i < kept; i++)
                  send(OP_TEXT, word[i]);
               n += kept;
            end
            3: begin
               if ($urandom_range(0, 1) == 0)
                  send(OP_UNUSED, SYMBOL_PORT_BITS'($urandom_range(0, 255)));
               else
                  send(OP_PATTERN, SYMBOL_PORT_BITS'($urandom_range(0, 255)));
            end
            4: begin
               send(OP_TEXT, SYMBOL_PORT_BITS'($urandom_range(0, 255)));
               n++;
            end
            default: begin
               send(OP_TEXT, alphabet[$urandom_range(0, kinds - 1)]);
               n++;
            end
         endcase
      end
   endtask

   initial begin : receiver
      int calm_left;
      calm_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_done = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
         end else if (!quiet) begin
            if ($urandom_range(0, 49) == 0) begin
               calm_left = $urandom_range(20, 150);
            end else if ($urandom_range(0, 5) == 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      int len;
      int pick;
      int waited;
      bit paused;
      paused        = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_CLEAR;
      req_symbol    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // unknown op, text with no pattern, pattern after text
      send(OP_UNUSED, 8'hFF);
      send(OP_TEXT, 8'h00);
      send(OP_PATTERN, 8'h41);
      send(OP_TEXT, 8'hFF);
      // symbol extremes, repeated symbol in the pattern
      send(OP_CLEAR, 8'hAA);
      send(OP_PATTERN, 8'h00);
      send(OP_PATTERN, 8'hFF);
      send(OP_PATTERN, 8'h00);
      send(OP_TEXT, 8'hFF);
      send(OP_TEXT, 8'h00);
      send(OP_TEXT, 8'h00);
      send(OP_TEXT, 8'hFF);
      send(OP_PATTERN, 8'h5A);
      send(OP_TEXT, 8'h80);
      send(OP_UNUSED, 8'h00);
      // single symbol pattern
      send(OP_CLEAR, 8'h00);
      send(OP_PATTERN, 8'h80);
      send(OP_TEXT, 8'h80);
      send(OP_TEXT, 8'h80);
      send(OP_TEXT, 8'h7F);

      // pattern longer than the window limit
      play_sequence(PATTERN_MAX_DEFAULT + 2, 90);

      while (sent_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) < 17) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               len = $urandom_range(PATTERN_MAX_DEFAULT, PATTERN_MAX_DEFAULT + 4);
            else if (pick < 4)
               len = $urandom_range(7, PATTERN_MAX_DEFAULT - 1);
            else
               len = $urandom_range(1, 6);
            play_sequence(len, $urandom_range(len, 3 * len + 12));
         end else begin
            repeat ($urandom_range(1, 8))
               send(OPERATION_BITS'($urandom_range(0, 3)),
                    SYMBOL_PORT_BITS'($urandom_range(0, 255)));
         end
         if (!long_hold_req && sent_items > 400) begin
            long_hold_req = 1'b1;
            play_sequence(1, 40);
         end
         if (!paused && sent_items > 800) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
      end

      // no idling from here on
      quiet = 1'b1;
      play_sequence(2, QUIET_TEXT);

      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d start indexes never arrived", $time, pending);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
